// ===== src/tboc_pkg.sv =====
// Package for the two-beam occupancy counter: sizes, register indexes,
// the result struct shared by the tracker and the top level.
// No dependencies.
package tboc_pkg;

  // Sizes of the occupant count and the millisecond timestamp.
  localparam int COUNT_BITS = 8;
  localparam int TIME_BITS  = 32;

  // Field widths.
  localparam int ECHO_W   = 15;
  localparam int RANGE_W  = 10;
  localparam int THRESH_W = 10;
  localparam int WINDOW_W = 16;
  localparam int LIMIT_W  = 8;
  localparam int NOW_W    = 32;

  // Distance conversion: cm = (echo_us * DIST_MUL) >> DIST_SHIFT.
  localparam int DIST_MUL_W = 11;
  localparam int PROD_W     = ECHO_W + DIST_MUL_W;
  localparam int DIST_SHIFT = 16;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL    = DIST_MUL_W'(1124);
  localparam logic [RANGE_W-1:0]    DIST_MAX_CM = RANGE_W'(400);
  localparam logic [RANGE_W-1:0]    DIST_NONE   = RANGE_W'(999);

  // Configuration register map.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  typedef enum logic [1:0] {
    REG_THRESH = 2'd0,
    REG_WINDOW = 2'd1,
    REG_LIMIT  = 2'd2
  } reg_idx_t;

  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(50);
  localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(1000);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(10);

  // One result transaction.
  typedef struct packed {
    logic [COUNT_BITS-1:0] occupants;
    logic                  alarm_on;
    logic                  alert_lamp;
    logic                  entry_seen;
    logic                  exit_seen;
    logic [RANGE_W-1:0]    range_a_cm;
    logic [RANGE_W-1:0]    range_b_cm;
  } result_t;

endpackage

// ===== src/tboc_if.sv =====
// Valid/ready channel interfaces for the occupancy counter's poll input
// and result output. Depends on tboc_pkg for field widths.
interface tboc_in_if import tboc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ECHO_W-1:0]   echo_a_us;
  logic [ECHO_W-1:0]   echo_b_us;
  logic [NOW_W-1:0]    now_ms;

  modport source (output valid, echo_a_us, echo_b_us, now_ms, input ready);
  modport sink   (input valid, echo_a_us, echo_b_us, now_ms, output ready);
endinterface

interface tboc_out_if import tboc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] occupants;
  logic                  alarm_on;
  logic                  alert_lamp;
  logic                  entry_seen;
  logic                  exit_seen;
  logic [RANGE_W-1:0]    range_a_cm;
  logic [RANGE_W-1:0]    range_b_cm;

  modport source (output valid, occupants, alarm_on, alert_lamp, entry_seen, exit_seen,
                  range_a_cm, range_b_cm, input ready);
  modport sink   (input valid, occupants, alarm_on, alert_lamp, entry_seen, exit_seen,
                  range_a_cm, range_b_cm, output ready);
endinterface

// ===== src/two_beam_occupancy_counter.sv =====
// Top level of the two-beam occupancy counter: input and result registers,
// APB register file, handshakes. Depends on tboc_pkg, tboc_if, tboc_range, tboc_track.
//
// Each poll transaction carries two ultrasonic echo times and a millisecond
// timestamp and yields exactly one result transaction with the occupant count,
// alarm and lamp drive, entry/exit flags and both beam distances in cm (999
// when out of range). A poll is captured in an input register; combinational
// logic (a 15x11 constant multiply per beam, compares and the pairing state)
// lies between it and the result register, which loads when that is free or being
// taken, so a stall there holds the poll back; one poll can be accepted every cycle
// while the result side keeps up. in_ch.ready falls only when both registers hold
// data and the result is not being taken. Registers sit at byte addresses
// 0 (threshold), 4 (pairing window) and 8 (capacity limit); write them only
// while no poll is in flight.
module two_beam_occupancy_counter import tboc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tboc_in_if.sink           in_ch,
  tboc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [THRESH_W-1:0]  thresh_r;
  logic [WINDOW_W-1:0]  window_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  logic                 in_valid_r;
  logic [ECHO_W-1:0]    echo_a_r, echo_b_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 out_valid_r;
  result_t              res_r;
  result_t              res;
  logic                 advance, in_take;
  logic [RANGE_W-1:0]   range_a, range_b;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      window_r <= WINDOW_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THRESH: thresh_r <= pwdata[THRESH_W-1:0];
        REG_WINDOW: window_r <= pwdata[WINDOW_W-1:0];
        REG_LIMIT:  limit_r  <= pwdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THRESH: prdata = DATA_W'(thresh_r);
      REG_WINDOW: prdata = DATA_W'(window_r);
      REG_LIMIT:  prdata = DATA_W'(limit_r);
      default:    prdata = '0;
    endcase
  end

  // Pipeline control: a poll moves on when the result register is free.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      echo_a_r <= in_ch.echo_a_us;
      echo_b_r <= in_ch.echo_b_us;
      now_r    <= in_ch.now_ms[TIME_BITS-1:0];
    end
  end

  tboc_range u_range_a (.echo_us(echo_a_r), .range_cm(range_a));
  tboc_range u_range_b (.echo_us(echo_b_r), .range_cm(range_b));

  tboc_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .range_a_cm (range_a),
    .range_b_cm (range_b),
    .now        (now_r),
    .thresh     (thresh_r),
    .window     (window_r),
    .limit      (limit_r),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) res_r <= res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.occupants  = res_r.occupants;
  assign out_ch.alarm_on   = res_r.alarm_on;
  assign out_ch.alert_lamp = res_r.alert_lamp;
  assign out_ch.entry_seen = res_r.entry_seen;
  assign out_ch.exit_seen  = res_r.exit_seen;
  assign out_ch.range_a_cm = res_r.range_a_cm;
  assign out_ch.range_b_cm = res_r.range_b_cm;

  // A poll never counts an entry and an exit at once.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.entry_seen && res_r.exit_seen))
    else $error("entry and exit reported in the same result");

  // The lamp only lights while the alarm is on.
  a_lamp_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.alert_lamp |-> res_r.alarm_on)
    else $error("lamp lit without alarm");

  // A stalled result register must not be overwritten by a new poll.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("result overwritten while stalled");

endmodule

// ===== src/tboc_range.sv =====
// Echo time to distance conversion for one beam, with out-of-range mapping.
// Depends on tboc_pkg.
module tboc_range import tboc_pkg::*; (
  input  logic [ECHO_W-1:0]  echo_us,
  output logic [RANGE_W-1:0] range_cm
);

  logic [PROD_W-1:0]  prod;
  logic [RANGE_W-1:0] dist_cm;

  // Fixed-point scale by 0.0343/2 cm per microsecond, truncated.
  assign prod    = PROD_W'(echo_us) * PROD_W'(DIST_MUL);
  assign dist_cm = prod[DIST_SHIFT +: RANGE_W];

  // No echo or beyond the sensor's range reads as the "none" code.
  assign range_cm = ((dist_cm == '0) || (dist_cm > DIST_MAX_CM)) ? DIST_NONE : dist_cm;

endmodule

// ===== src/tboc_track.sv =====
// Pairing window, occupant count and alarm/lamp state for the counter.
// Depends on tboc_pkg; results leave as a result_t.
module tboc_track import tboc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [RANGE_W-1:0]   range_a_cm,
  input  logic [RANGE_W-1:0]   range_b_cm,
  input  logic [TIME_BITS-1:0] now,
  input  logic [THRESH_W-1:0]  thresh,
  input  logic [WINDOW_W-1:0]  window,
  input  logic [LIMIT_W-1:0]   limit,
  output result_t              res
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  armed_r, armed_nxt;
  logic                  first_b_r, first_b_nxt;
  logic [TIME_BITS-1:0]  arm_time_r, arm_time_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  lamp_r, lamp_nxt;
  logic                  blk_a, blk_b;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  entry, leave, alarm;

  assign blk_a   = range_a_cm < thresh;
  assign blk_b   = range_b_cm < thresh;
  assign elapsed = now - arm_time_r;

  // Arm on a single blocked beam; when armed, expiry wins over a pairing.
  always_comb begin
    armed_nxt    = armed_r;
    first_b_nxt  = first_b_r;
    arm_time_nxt = arm_time_r;
    count_nxt    = count_r;
    entry        = 1'b0;
    leave        = 1'b0;
    if (!armed_r) begin
      if (blk_a != blk_b) begin
        armed_nxt    = 1'b1;
        first_b_nxt  = blk_b;
        arm_time_nxt = now;
      end
    end else begin
      priority if (elapsed > TIME_BITS'(window)) begin
        armed_nxt = 1'b0;
      end else if (!first_b_r && blk_b) begin
        entry     = 1'b1;
        armed_nxt = 1'b0;
        if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
      end else if (first_b_r && blk_a) begin
        leave     = 1'b1;
        armed_nxt = 1'b0;
        if (count_r != '0) count_nxt = count_r - 1'b1;
      end
    end
  end

  // Alarm when full; the lamp blinks while full and is dark otherwise.
  assign alarm    = 16'(count_nxt) >= 16'(limit);
  assign lamp_nxt = alarm ? ~lamp_r : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      first_b_r  <= 1'b0;
      arm_time_r <= '0;
      count_r    <= '0;
      lamp_r     <= 1'b0;
    end else if (step) begin
      armed_r    <= armed_nxt;
      first_b_r  <= first_b_nxt;
      arm_time_r <= arm_time_nxt;
      count_r    <= count_nxt;
      lamp_r     <= lamp_nxt;
    end
  end

  always_comb begin
    res.occupants  = count_nxt;
    res.alarm_on   = alarm;
    res.alert_lamp = lamp_nxt;
    res.entry_seen = entry;
    res.exit_seen  = leave;
    res.range_a_cm = range_a_cm;
    res.range_b_cm = range_b_cm;
  end

endmodule

// ===== verif/tboc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the two-beam occupancy counter: watches the poll, result and register
// buses, predicts each result and compares it field by field.
// Depends on tboc_pkg and tboc_if.
module occupancy_checker import tboc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tboc_in_if                in_mon,
  tboc_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending
);

  // Shadow copy of the registers and of the pairing state.
  logic [THRESH_W-1:0]   thresh_q;
  logic [WINDOW_W-1:0]   window_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic                  armed_q;
  logic                  first_is_b;
  logic [TIME_BITS-1:0]  arm_ms;
  logic [COUNT_BITS-1:0] heads;
  logic                  lamp_q;

  // Results owed by the block, oldest first.
  result_t results_due[$];

  // Whole-cm distance of one echo; 999 when nothing sensible came back.
  function automatic logic [RANGE_W-1:0] echo_to_range(input logic [ECHO_W-1:0] echo);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-DIST_SHIFT-1:0] cm;
    prod = PROD_W'(echo) * PROD_W'(DIST_MUL);
    cm   = prod[PROD_W-1:DIST_SHIFT];
    if (cm == '0 || cm > DIST_MAX_CM) begin
      return DIST_NONE;
    end
    return RANGE_W'(cm);
  endfunction

  // Advances the pairing state by one poll and returns the result it owes.
  task automatic step_occupancy(input logic [ECHO_W-1:0] echo_a, input logic [ECHO_W-1:0] echo_b,
                                input logic [NOW_W-1:0] now, output result_t res);
    logic [RANGE_W-1:0]   ra;
    logic [RANGE_W-1:0]   rb;
    logic                 blk_a;
    logic                 blk_b;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    ra    = echo_to_range(echo_a);
    rb    = echo_to_range(echo_b);
    blk_a = ra < thresh_q;
    blk_b = rb < thresh_q;
    now_t = now[TIME_BITS-1:0];
    res   = '0;

    if (!armed_q) begin
      // A single blocked beam opens the window; both blocked does nothing.
      if (blk_a && !blk_b) begin
        armed_q    = 1'b1;
        first_is_b = 1'b0;
        arm_ms     = now_t;
      end else if (blk_b && !blk_a) begin
        armed_q    = 1'b1;
        first_is_b = 1'b1;
        arm_ms     = now_t;
      end
    end else begin
      // Expiry wins over a second beam arriving too late.
      elapsed = now_t - arm_ms;
      if (elapsed > TIME_BITS'(window_q)) begin
        armed_q = 1'b0;
      end else if (!first_is_b && blk_b) begin
        if (heads != '1) begin
          heads = heads + 1'b1;
        end
        res.entry_seen = 1'b1;
        armed_q        = 1'b0;
      end else if (first_is_b && blk_a) begin
        if (heads != '0) begin
          heads = heads - 1'b1;
        end
        res.exit_seen = 1'b1;
        armed_q       = 1'b0;
      end
    end

    // Alarm and blinking while at or over the limit; lamp dark otherwise.
    if (heads >= COUNT_BITS'(limit_q)) begin
      res.alarm_on = 1'b1;
      lamp_q       = ~lamp_q;
    end else begin
      lamp_q = 1'b0;
    end

    res.occupants  = heads;
    res.alert_lamp = lamp_q;
    res.range_a_cm = ra;
    res.range_b_cm = rb;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string field, input int unsigned seen, input int unsigned want);
    if (seen != want) begin
      report_mismatch($sformatf("%s is %0d, predicted %0d", field, seen, want));
    end
  endtask

  // Register writes, result checks and poll predictions, all on the rising edge.
  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      thresh_q   = THRESH_RST;
      window_q   = WINDOW_RST;
      limit_q    = LIMIT_RST;
      armed_q    = 1'b0;
      first_is_b = 1'b0;
      arm_ms     = '0;
      heads      = '0;
      lamp_q     = 1'b0;
      fail_count = 0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_THRESH: thresh_q = pwdata[THRESH_W-1:0];
          REG_WINDOW: window_q = pwdata[WINDOW_W-1:0];
          REG_LIMIT:  limit_q  = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transaction arrived with no poll outstanding");
        end else begin
          want = results_due.pop_front();
          check_field("occupants", out_mon.occupants, want.occupants);
          check_field("alarm_on", out_mon.alarm_on, want.alarm_on);
          check_field("alert_lamp", out_mon.alert_lamp, want.alert_lamp);
          check_field("entry_seen", out_mon.entry_seen, want.entry_seen);
          check_field("exit_seen", out_mon.exit_seen, want.exit_seen);
          check_field("range_a_cm", out_mon.range_a_cm, want.range_a_cm);
          check_field("range_b_cm", out_mon.range_b_cm, want.range_b_cm);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        step_occupancy(in_mon.echo_a_us, in_mon.echo_b_us, in_mon.now_ms, fresh);
        results_due.push_back(fresh);
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the two-beam occupancy counter: clock, reset, poll stimulus,
// result-side back-pressure, register writes and the verdict.
// Depends on tboc_pkg, tboc_if, the counter RTL and occupancy_checker.
module tb_top import tboc_pkg::*; ;

  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending_results;

  // Stimulus knobs shared with the receiver process.
  int          tx_idle_pct = 30;
  int          rx_idle_pct = 30;
  int          rx_hold = 0;
  int          polls_sent = 0;
  int          idle_cycles = 0;
  int          cur_thresh = 50;
  int          cur_window = 1000;
  logic [NOW_W-1:0] clock_ms = '0;

  tboc_in_if  poll_ch ();
  tboc_out_if res_ch ();

  two_beam_occupancy_counter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (poll_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  occupancy_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (poll_ch),
    .out_mon    (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending_results)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Echo time that reads below the current threshold, where one exists.
  function automatic logic [ECHO_W-1:0] blocked_echo();
    if (cur_thresh > 999 || cur_thresh <= 1) begin
      return ECHO_W'($urandom);
    end
    return ECHO_W'($urandom_range(59, (cur_thresh - 1) * 58));
  endfunction

  // Echo time that reads at or above the threshold, where one exists: no echo, too far, or in range.
  function automatic logic [ECHO_W-1:0] clear_echo();
    int pick;
    pick = $urandom_range(0, 3);
    if (cur_thresh > 999) begin
      return ECHO_W'($urandom);
    end
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1 || cur_thresh > 387) begin
      return ECHO_W'($urandom_range(23400, 32767));
    end
    return ECHO_W'($urandom_range(cur_thresh * 60 + 60, 23300));
  endfunction

  // Offers one poll; called at a falling edge and returns at one.
  task automatic send_poll(input logic [ECHO_W-1:0] echo_a, input logic [ECHO_W-1:0] echo_b,
                           input logic [NOW_W-1:0] now);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = gap_len();
    end
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_ch.valid     <= 1'b1;
    poll_ch.echo_a_us <= echo_a;
    poll_ch.echo_b_us <= echo_b;
    poll_ch.now_ms    <= now;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    polls_sent++;
    @(negedge clk);
  endtask

  // Stops offering polls until every result is back.
  task automatic drain();
    poll_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int thresh, input int window, input int limit);
    drain();
    write_reg(REG_THRESH, DATA_W'(thresh));
    write_reg(REG_WINDOW, DATA_W'(window));
    write_reg(REG_LIMIT, DATA_W'(limit));
    cur_thresh = thresh;
    cur_window = window;
  endtask

  // One walk-through: first beam alone, optional loitering, then the second beam,
  // either inside the window or past it.
  task automatic passage(input bit is_exit, input int loiter, input bit late);
    int unsigned      span;
    logic [NOW_W-1:0] t0;
    logic [NOW_W-1:0] t_end;
    logic [ECHO_W-1:0] first_echo;
    span  = late ? cur_window + 1 + $urandom_range(0, 500) : $urandom_range(0, cur_window);
    t0    = clock_ms;
    t_end = t0 + span;
    if (is_exit) begin
      send_poll(clear_echo(), blocked_echo(), t0);
    end else begin
      send_poll(blocked_echo(), clear_echo(), t0);
    end
    repeat (loiter) begin
      first_echo = $urandom_range(0, 1) ? blocked_echo() : clear_echo();
      if (is_exit) begin
        send_poll(clear_echo(), first_echo, t0 + $urandom_range(0, span));
      end else begin
        send_poll(first_echo, clear_echo(), t0 + $urandom_range(0, span));
      end
    end
    first_echo = $urandom_range(0, 1) ? blocked_echo() : clear_echo();
    if (is_exit) begin
      send_poll(blocked_echo(), first_echo, t_end);
    end else begin
      send_poll(first_echo, blocked_echo(), t_end);
    end
    clock_ms = t_end + $urandom_range(1, 60);
  endtask

  // Random polls with no structure: any echo bits, any timestamp now and then.
  task automatic noise_poll();
    if ($urandom_range(0, 9) == 0) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 100);
    end
    send_poll(ECHO_W'($urandom), ECHO_W'($urandom), clock_ms);
  endtask

  // Mostly well-formed passages with random content, the rest noise.
  task automatic run_mixed(input int polls, input int exit_pct);
    int stop_at;
    stop_at = polls_sent + polls;
    while (polls_sent < stop_at) begin
      if ($urandom_range(0, 99) < 75) begin
        passage($urandom_range(0, 99) < exit_pct,
                ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 2),
                $urandom_range(0, 99) < 10);
      end else begin
        noise_poll();
      end
    end
  endtask

  // Result-side ready: random gaps, plus a long hold when requested.
  initial begin
    int gap_left;
    gap_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        res_ch.ready <= 1'b0;
        rx_hold--;
      end else if (gap_left > 0) begin
        res_ch.ready <= 1'b0;
        gap_left--;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        res_ch.ready <= 1'b0;
        gap_left = gap_len() - 1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction or register write ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    poll_ch.valid     = 1'b0;
    poll_ch.echo_a_us = '0;
    poll_ch.echo_b_us = '0;
    poll_ch.now_ms    = '0;
    res_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed polls at the reset settings (threshold 50, window 1000, limit 10).
    send_poll(15'd0, 15'd0, 32'd0);                   // no echo on either beam
    send_poll(15'h7FFF, 15'd30000, 32'd5);            // far beyond range
    send_poll(15'd58, 15'd1, 32'd7);                  // under one cm
    send_poll(15'd23323, 15'd23385, 32'd9);           // 400 cm and 401 cm
    send_poll(15'd5830, 15'd1000, 32'd10);            // B alone arms an exit
    send_poll(15'd1000, 15'd5830, 32'd20);            // exit while empty
    send_poll(15'd1000, 15'd1000, 32'd30);            // both blocked while idle
    send_poll(15'd1000, 15'd5830, 32'd40);            // A alone arms an entry
    send_poll(15'd1000, 15'd0, 32'd500);              // A again, still armed
    send_poll(15'd0, 15'd0, 32'd700);                 // both clear
    send_poll(15'd5830, 15'd1000, 32'd1040);          // B on the last ms of the window
    send_poll(15'd1000, 15'd5830, 32'd2000);          // arm A
    send_poll(15'd1000, 15'd1000, 32'd3001);          // one ms late: expiry beats B
    send_poll(15'd2916, 15'd2915, 32'd3002);          // 50 cm is clear, 49 cm blocked
    send_poll(15'd2915, 15'd0, 32'd3003);             // exit counted
    send_poll(15'd1000, 15'd5830, 32'hFFFF_FFF0);     // arm A just before the wrap
    send_poll(15'd5830, 15'd1000, 32'h0000_0010);     // entry across the wrap
    send_poll(15'd1000, 15'd5830, 32'hFFFF_FFFF);     // arm A at the top timestamp
    send_poll(15'd0, 15'd1000, 32'h0000_0000);        // entry one ms later

    // Low limit: lamp blinking; a pause until all results are back midway.
    configure(80, 500, 5);
    clock_ms = 32'd100000;
    run_mixed(15, 50);
    drain();
    run_mixed(15, 50);

    // Entries only, widest window, up to the count ceiling and past it.
    configure(300, 65535, 255);
    clock_ms    = 32'hFFF0_0000;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (130) passage(1'b0, 0, 1'b0);
    tx_idle_pct = 15;
    rx_idle_pct = 40;
    repeat (132) passage(1'b0, 0, 1'b0);

    // Everything blocked, zero window, zero limit.
    configure(1000, 0, 0);
    tx_idle_pct = 50;
    rx_idle_pct = 10;
    run_mixed(20, 50);

    // Nothing can block.
    configure(0, 200, 100);
    tx_idle_pct = 10;
    rx_idle_pct = 50;
    run_mixed(15, 50);

    // Mostly exits; the receiver holds off while polls keep coming.
    configure(120, 2000, 250);
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    run_mixed(15, 80);
    rx_hold     = 60;
    tx_idle_pct = 0;
    repeat (6) passage(1'b1, 0, 1'b0);
    tx_idle_pct = 20;
    run_mixed(15, 80);

    // Threshold at its register maximum, short window, limit of one.
    configure(1023, 30, 1);
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    run_mixed(15, 50);

    poll_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tboc_pkg.sv
src/tboc_if.sv
src/tboc_range.sv
src/tboc_track.sv
src/two_beam_occupancy_counter.sv
verif/tboc_checker.sv
verif/tb_top.sv
